// File: hw/rtl/odt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odt_pkg
// Shared types and constants of the oxygen desaturation tracker.
// ----------------------------------------------------------------------------
package odt_pkg;

  // Stream payload widths.
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 136;

  // Configuration port widths.
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // Register indexes, at byte address 4*index.
  typedef enum logic [2:0] {
    REG_WINDOW  = 3'd0,
    REG_DROP    = 3'd1,
    REG_RELEASE = 3'd2,
    REG_HIGH    = 3'd3,
    REG_LOW     = 3'd4
  } reg_idx_t;

  // Register reset values.
  localparam logic [7:0] WINDOW_RST  = 8'd30;
  localparam logic [7:0] DROP_RST    = 8'd3;
  localparam logic [7:0] RELEASE_RST = 8'd1;
  localparam logic [7:0] HIGH_RST    = 8'd90;
  localparam logic [7:0] LOW_RST     = 8'd88;

  // Smallest window the baseline search uses.
  localparam int unsigned MIN_WINDOW = 2;

endpackage

// File: hw/rtl/oximetry_desaturation_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oximetry_desaturation_tracker_core
// Oxygen desaturation event detector with running SpO2 and heart-rate stats.
// ----------------------------------------------------------------------------
// Sequence: an accepted request passes through ST_PREP, ST_SCAN and ST_FINISH;
//   ST_SCAN reads the stored window positions searched (at most MAX_WINDOW)
//   and finds nothing to read for an invalid sample or an empty history.
// Requests: one at a time, through the single compare unit; a new one is taken
//   only back in ST_IDLE, and while the last result stalls it waits in ST_FINISH.
// Reset: synchronous active-low rst_n clears state; window memory is not cleared.
module oximetry_desaturation_tracker_core #(
  parameter int unsigned MAX_WINDOW = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata from bit 0: spo2[7:0], pulse_rate[15:8]
  input  logic [odt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser from bit 0: restart[0], sample_valid[1]
  input  logic [odt_pkg::IN_TUSER_W-1:0]   in_tuser,
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata from bit 0: event_start[0], in_event[1], event_count[17:2],
  // local_baseline[25:18], spo2_min[33:26], spo2_max[41:34], min_hr[49:42],
  // max_hr[57:50], below_high_count[81:58], below_low_count[105:82],
  // valid_count[129:106], zero fill[135:130]
  output logic [odt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // Configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [odt_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [odt_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [odt_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);

  // Address width of the window ring, width of the fill count (it must hold
  // MAX_WINDOW itself), and a compare width wide enough for both the 8-bit
  // window register and the fill count.
  localparam int unsigned AW = $clog2(MAX_WINDOW);
  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CW = (FW > 8) ? FW : 8;

  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);
  localparam logic [FW-1:0] FILL_MAX  = FW'(MAX_WINDOW);
  localparam logic [CW-1:0] WIN_MAX   = CW'(MAX_WINDOW);
  localparam logic [CW-1:0] WIN_MIN   = CW'(odt_pkg::MIN_WINDOW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers. The port never waits; a write lands at the edge
  // of the access phase. Reads return the register zero-extended.
  // --------------------------------------------------------------------------
  logic [7:0] cfg_window_r, cfg_drop_r, cfg_release_r, cfg_high_r, cfg_low_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_window_r  <= odt_pkg::WINDOW_RST;
      cfg_drop_r    <= odt_pkg::DROP_RST;
      cfg_release_r <= odt_pkg::RELEASE_RST;
      cfg_high_r    <= odt_pkg::HIGH_RST;
      cfg_low_r     <= odt_pkg::LOW_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        odt_pkg::REG_WINDOW:  cfg_window_r  <= cfg_pwdata[7:0];
        odt_pkg::REG_DROP:    cfg_drop_r    <= cfg_pwdata[7:0];
        odt_pkg::REG_RELEASE: cfg_release_r <= cfg_pwdata[7:0];
        odt_pkg::REG_HIGH:    cfg_high_r    <= cfg_pwdata[7:0];
        odt_pkg::REG_LOW:     cfg_low_r     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      odt_pkg::REG_WINDOW:  cfg_prdata = {24'd0, cfg_window_r};
      odt_pkg::REG_DROP:    cfg_prdata = {24'd0, cfg_drop_r};
      odt_pkg::REG_RELEASE: cfg_prdata = {24'd0, cfg_release_r};
      odt_pkg::REG_HIGH:    cfg_prdata = {24'd0, cfg_high_r};
      odt_pkg::REG_LOW:     cfg_prdata = {24'd0, cfg_low_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and running statistics.
  // --------------------------------------------------------------------------
  state_t          state_r;
  logic [7:0]      spo2_r, hr_r;
  logic            valid_r;
  logic [AW-1:0]   slot_r;        // next ring position to write
  logic [FW-1:0]   fill_r;        // positions written since reset or restart
  logic [FW-1:0]   span_r;        // positions to search for this request
  logic [FW-1:0]   issue_r;       // positions read so far
  logic [AW-1:0]   rd_ptr_r;
  logic            rd_vld_r;
  logic [7:0]      rd_data_r;
  logic [7:0]      base_r;
  logic            active_r;
  logic [15:0]     events_r;
  logic [7:0]      spo2_lo_r, spo2_hi_r, hr_lo_r, hr_hi_r;
  logic [23:0]     under_hi_r, under_lo_r, valid_cnt_r;
  logic            out_tvalid_r;
  logic [odt_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic [7:0] window_mem [MAX_WINDOW];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Effective window, clamped into [2, MAX_WINDOW], then limited by history.
  logic [CW-1:0] win_ext, win_clamp, fill_ext;
  logic [FW-1:0] span_calc;

  always_comb begin
    win_ext  = CW'(cfg_window_r);
    fill_ext = CW'(fill_r);
    if (win_ext < WIN_MIN) begin
      win_clamp = WIN_MIN;
    end else if (win_ext > WIN_MAX) begin
      win_clamp = WIN_MAX;
    end else begin
      win_clamp = win_ext;
    end
    span_calc = (win_clamp < fill_ext) ? FW'(win_clamp) : fill_r;
  end

  // Decision logic for the finishing step.
  logic        out_free, finish_go, do_start;
  logic [7:0]  drop;
  logic        rd_issue;

  assign out_free  = !out_tvalid_r || out_tready;
  assign finish_go = (state_r == ST_FINISH) && out_free;
  assign drop      = base_r - spo2_r;
  assign do_start  = valid_r && (drop >= cfg_drop_r) && !active_r;
  assign rd_issue  = (state_r == ST_SCAN) && (issue_r < span_r);

  // Window ring: one write port at the finishing step, one registered read.
  always_ff @(posedge clk) begin
    if (finish_go) begin
      window_mem[slot_r] <= valid_r ? spo2_r : 8'd0;
    end
    rd_data_r <= window_mem[rd_ptr_r];
  end

  // Result fields as they stand after the finishing step.
  logic        nx_active;
  logic [15:0] nx_events;
  logic [7:0]  nx_base, nx_spo2_lo, nx_spo2_hi, nx_hr_lo, nx_hr_hi;
  logic [23:0] nx_under_hi, nx_under_lo, nx_valid_cnt;

  always_comb begin
    nx_active    = active_r;
    nx_events    = events_r;
    nx_base      = 8'd0;
    nx_spo2_lo   = spo2_lo_r;
    nx_spo2_hi   = spo2_hi_r;
    nx_hr_lo     = hr_lo_r;
    nx_hr_hi     = hr_hi_r;
    nx_under_hi  = under_hi_r;
    nx_under_lo  = under_lo_r;
    nx_valid_cnt = valid_cnt_r;
    if (valid_r) begin
      nx_base = base_r;
      if (do_start) begin
        nx_active = 1'b1;
        if (events_r != '1) nx_events = events_r + 16'd1;
      end else if (drop < cfg_release_r) begin
        nx_active = 1'b0;
      end
      if (valid_cnt_r != '1) nx_valid_cnt = valid_cnt_r + 24'd1;
      if (spo2_r < spo2_lo_r) nx_spo2_lo = spo2_r;
      if (spo2_r > spo2_hi_r) nx_spo2_hi = spo2_r;
      if (hr_r < hr_lo_r) nx_hr_lo = hr_r;
      if (hr_r > hr_hi_r) nx_hr_hi = hr_r;
      if ((spo2_r < cfg_high_r) && (under_hi_r != '1)) nx_under_hi = under_hi_r + 24'd1;
      if ((spo2_r < cfg_low_r) && (under_lo_r != '1)) nx_under_lo = under_lo_r + 24'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= '0;
      fill_r       <= '0;
      span_r       <= '0;
      issue_r      <= '0;
      rd_ptr_r     <= '0;
      rd_vld_r     <= 1'b0;
      active_r     <= 1'b0;
      events_r     <= '0;
      spo2_lo_r    <= 8'hFF;
      spo2_hi_r    <= 8'd0;
      hr_lo_r      <= 8'hFF;
      hr_hi_r      <= 8'd0;
      under_hi_r   <= '0;
      under_lo_r   <= '0;
      valid_cnt_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // A result taken in the same cycle as the next one is loaded stays valid.
      if (out_tvalid_r && out_tready && !finish_go) out_tvalid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            spo2_r  <= in_tdata[7:0];
            hr_r    <= in_tdata[15:8];
            valid_r <= in_tuser[1];
            // A restart clears the running state before this sample.
            if (in_tuser[0]) begin
              slot_r      <= '0;
              fill_r      <= '0;
              active_r    <= 1'b0;
              events_r    <= '0;
              spo2_lo_r   <= 8'hFF;
              spo2_hi_r   <= 8'd0;
              hr_lo_r     <= 8'hFF;
              hr_hi_r     <= 8'd0;
              under_hi_r  <= '0;
              under_lo_r  <= '0;
              valid_cnt_r <= '0;
            end
            state_r <= ST_PREP;
          end
        end

        ST_PREP: begin
          // Search starts at the most recent stored position and walks back.
          base_r   <= spo2_r;
          span_r   <= valid_r ? span_calc : '0;
          issue_r  <= '0;
          rd_vld_r <= 1'b0;
          rd_ptr_r <= (slot_r == '0) ? LAST_SLOT : slot_r - AW'(1);
          state_r  <= ST_SCAN;
        end

        ST_SCAN: begin
          // Reads are issued one per cycle; the compare takes the data in the
          // next cycle from the registered read port.
          if (rd_issue) begin
            issue_r  <= issue_r + FW'(1);
            rd_vld_r <= 1'b1;
            rd_ptr_r <= (rd_ptr_r == '0) ? LAST_SLOT : rd_ptr_r - AW'(1);
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r && (rd_data_r > base_r)) base_r <= rd_data_r;
          if (!rd_issue && !rd_vld_r) state_r <= ST_FINISH;
        end

        ST_FINISH: begin
          if (out_free) begin
            active_r     <= nx_active;
            events_r     <= nx_events;
            spo2_lo_r    <= nx_spo2_lo;
            spo2_hi_r    <= nx_spo2_hi;
            hr_lo_r      <= nx_hr_lo;
            hr_hi_r      <= nx_hr_hi;
            under_hi_r   <= nx_under_hi;
            under_lo_r   <= nx_under_lo;
            valid_cnt_r  <= nx_valid_cnt;
            slot_r       <= (slot_r == LAST_SLOT) ? '0 : slot_r + AW'(1);
            if (fill_r != FILL_MAX) fill_r <= fill_r + FW'(1);
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {6'd0, nx_valid_cnt, nx_under_lo, nx_under_hi,
                             nx_hr_hi, nx_hr_lo, nx_spo2_hi, nx_spo2_lo,
                             nx_base, nx_events, nx_active, do_start};
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/odt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odt_checker
// Port-level checks of the desaturation tracker, bound to its top level.
// ----------------------------------------------------------------------------
module odt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [odt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // Reset empties the output stage.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A starting event is active and counted.
  a_start_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1] && (out_tdata[17:2] != 16'd0))
    else $error("event start without active, counted event");

endmodule

bind oximetry_desaturation_tracker_core odt_checker u_odt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: dv/oximetry_desaturation_tracker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oximetry_desaturation_tracker_core_test
// Self-checking bench: drives SpO2 / heart-rate samples through the input
// stream, writes the thresholds over the APB port between phases, and checks
// every result against an in-bench model of the tracker.
// ----------------------------------------------------------------------------
module oximetry_desaturation_tracker_core_test;

  localparam int unsigned WIN_DEPTH   = 128;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 125;

  // One result of the tracker, split into its fields.
  typedef struct {
    logic        event_start;
    logic        in_event;
    logic [15:0] event_count;
    logic [7:0]  baseline;
    logic [7:0]  spo2_min;
    logic [7:0]  spo2_max;
    logic [7:0]  hr_min;
    logic [7:0]  hr_max;
    logic [23:0] under_high;
    logic [23:0] under_low;
    logic [23:0] valid_cnt;
  } summary_t;

  // The scoreboard keeps its own copy of the tracker state and registers,
  // predicts one summary per accepted sample and checks the results in order.
  class desat_scoreboard;
    bit [7:0] win_reg, drop_reg, release_reg, high_reg, low_reg;
    bit [7:0] spo2_hist[WIN_DEPTH];
    int       fill, wr_slot;
    bit       desat_on;
    int       events, spo2_lo, spo2_hi, hr_lo, hr_hi;
    int       under_hi_tot, under_lo_tot, valid_tot;
    summary_t pending_summaries[$];
    int       errors, checked, starts;

    function new();
      win_reg     = odt_pkg::WINDOW_RST;
      drop_reg    = odt_pkg::DROP_RST;
      release_reg = odt_pkg::RELEASE_RST;
      high_reg    = odt_pkg::HIGH_RST;
      low_reg     = odt_pkg::LOW_RST;
      clear_state();
    endfunction

    function void clear_state();
      fill         = 0;
      wr_slot      = 0;
      desat_on     = 0;
      events       = 0;
      spo2_lo      = 255;
      spo2_hi      = 0;
      hr_lo        = 255;
      hr_hi        = 0;
      under_hi_tot = 0;
      under_lo_tot = 0;
      valid_tot    = 0;
    endfunction

    // Only the low byte is kept; unlisted indexes leave everything alone.
    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        odt_pkg::REG_WINDOW:  win_reg     = value[7:0];
        odt_pkg::REG_DROP:    drop_reg    = value[7:0];
        odt_pkg::REG_RELEASE: release_reg = value[7:0];
        odt_pkg::REG_HIGH:    high_reg    = value[7:0];
        odt_pkg::REG_LOW:     low_reg     = value[7:0];
        default: ;
      endcase
    endfunction

    function void note_sample(bit restart, bit [7:0] spo2, bit [7:0] hr, bit valid);
      summary_t s;
      int win, span, slot, base, drop;
      if (restart) clear_state();
      base = 0;
      s.event_start = 0;
      if (valid) begin
        win = win_reg;
        if (win < odt_pkg::MIN_WINDOW) win = odt_pkg::MIN_WINDOW;
        if (win > WIN_DEPTH) win = WIN_DEPTH;
        span = (win < fill) ? win : fill;
        base = spo2;
        for (int t = 0; t < span; t++) begin
          slot = (wr_slot + WIN_DEPTH - 1 - t) % WIN_DEPTH;
          if (spo2_hist[slot] > base) base = spo2_hist[slot];
        end
        drop = base - spo2;
        if (drop >= drop_reg && !desat_on) begin
          if (events < 16'hFFFF) events++;
          desat_on      = 1;
          s.event_start = 1;
          starts++;
        end else if (drop < release_reg) begin
          desat_on = 0;
        end
        if (valid_tot < 24'hFFFFFF) valid_tot++;
        if (spo2 < spo2_lo) spo2_lo = spo2;
        if (spo2 > spo2_hi) spo2_hi = spo2;
        if (hr < hr_lo) hr_lo = hr;
        if (hr > hr_hi) hr_hi = hr;
        if (spo2 < high_reg && under_hi_tot < 24'hFFFFFF) under_hi_tot++;
        if (spo2 < low_reg && under_lo_tot < 24'hFFFFFF) under_lo_tot++;
      end
      // Invalid positions sit in the window as zero.
      spo2_hist[wr_slot] = valid ? spo2 : 8'd0;
      wr_slot = (wr_slot + 1) % WIN_DEPTH;
      if (fill < WIN_DEPTH) fill++;

      s.in_event    = desat_on;
      s.event_count = events[15:0];
      s.baseline    = base[7:0];
      s.spo2_min    = spo2_lo[7:0];
      s.spo2_max    = spo2_hi[7:0];
      s.hr_min      = hr_lo[7:0];
      s.hr_max      = hr_hi[7:0];
      s.under_high  = under_hi_tot[23:0];
      s.under_low   = under_lo_tot[23:0];
      s.valid_cnt   = valid_tot[23:0];
      pending_summaries = {pending_summaries, s};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want)
        report($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                         checked, name, got, want));
    endtask

    task check_result(logic [odt_pkg::OUT_TDATA_W-1:0] data);
      summary_t w;
      if (pending_summaries.size() == 0) begin
        report($sformatf("result %0d arrived with no sample outstanding", checked));
        checked++;
        return;
      end
      w = pending_summaries.pop_front();
      check_field("event_start",      24'(data[0]),       24'(w.event_start));
      check_field("in_event",         24'(data[1]),       24'(w.in_event));
      check_field("event_count",      24'(data[17:2]),    24'(w.event_count));
      check_field("local_baseline",   24'(data[25:18]),   24'(w.baseline));
      check_field("spo2_min",         24'(data[33:26]),   24'(w.spo2_min));
      check_field("spo2_max",         24'(data[41:34]),   24'(w.spo2_max));
      check_field("min_hr",           24'(data[49:42]),   24'(w.hr_min));
      check_field("max_hr",           24'(data[57:50]),   24'(w.hr_max));
      check_field("below_high_count", data[81:58],        w.under_high);
      check_field("below_low_count",  data[105:82],       w.under_low);
      check_field("valid_count",      data[129:106],      w.valid_cnt);
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic                            in_tvalid;
  logic                            in_tready;
  // tdata from bit 0: spo2[7:0], pulse_rate[15:8]
  logic [odt_pkg::IN_TDATA_W-1:0]  in_tdata;
  // tuser from bit 0: restart[0], sample_valid[1]
  logic [odt_pkg::IN_TUSER_W-1:0]  in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  // tdata from bit 0: event_start, in_event, event_count, local_baseline,
  // spo2_min, spo2_max, min_hr, max_hr, below_high_count, below_low_count,
  // valid_count, zero fill
  logic [odt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [odt_pkg::CFG_AW-1:0]      cfg_paddr;
  logic [odt_pkg::CFG_DW-1:0]      cfg_pwdata;
  logic [odt_pkg::CFG_DW-1:0]      cfg_prdata;
  logic                            cfg_pready;

  desat_scoreboard board;
  bit              steady;      // when set, neither side inserts idle cycles
  int              spo2_level;  // slowly wandering saturation for the random part
  int              sent;
  int unsigned     cycle_count;

  oximetry_desaturation_tracker_core #(
    .MAX_WINDOW(WIN_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("oximetry_desaturation_tracker_core_test: done, errors");
      $finish;
    end
  end

  // Sends one sample request. The valid line is only lowered when a gap is
  // drawn, so back-to-back requests never see two assignments in one step.
  task automatic send_sample(bit restart, bit [7:0] spo2, bit [7:0] hr, bit valid);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hr, spo2};
    in_tuser  <= {valid, restart};
    do @(posedge clk); while (!in_tready);
    board.note_sample(restart, spo2, hr, valid);
    sent++;
  endtask

  // Accepts results with a random stall in front of each one.
  task automatic receive_results();
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_result(out_tdata);
    end
  endtask

  // APB write: setup phase, access phase, then the bus returns to idle.
  task automatic write_reg(logic [odt_pkg::CFG_AW-1:0] addr, logic [7:0] value);
    logic [31:0] data;
    // Upper data bits are sometimes noise; only the low byte is meaningful.
    data = {($urandom_range(0, 1) ? 24'($urandom) : 24'd0), value};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.set_reg(addr[4:2], data);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(bit [7:0] win, bit [7:0] drop, bit [7:0] rel,
                           bit [7:0] hi, bit [7:0] lo);
    write_reg({odt_pkg::REG_WINDOW, 2'b00}, win);
    write_reg({odt_pkg::REG_DROP, 2'b00}, drop);
    write_reg({odt_pkg::REG_RELEASE, 2'b00}, rel);
    write_reg({odt_pkg::REG_HIGH, 2'b00}, hi);
    write_reg({odt_pkg::REG_LOW, 2'b00}, lo);
  endtask

  // Stops requesting and waits until every predicted result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending_summaries.size() > 0) @(posedge clk);
  endtask

  // Mostly a plausible overnight trace: saturation recovering toward the
  // upper nineties with occasional dips, plus noise, invalid samples and
  // rare restarts.
  task automatic random_sample();
    int pick;
    bit restart, valid;
    bit [7:0] spo2, hr;
    pick    = $urandom_range(0, 99);
    restart = ($urandom_range(0, 99) == 0);
    valid   = 1'b1;
    hr      = 8'($urandom_range(45, 110));
    if (pick < 8) begin
      spo2 = 8'($urandom);
      hr   = 8'($urandom);
    end else begin
      if (pick < 20) spo2_level -= $urandom_range(2, 9);
      else if (spo2_level < 97) spo2_level += $urandom_range(0, 2);
      else spo2_level -= $urandom_range(0, 1);
      if (spo2_level < 50) spo2_level = 50;
      if (spo2_level > 100) spo2_level = 100;
      spo2 = 8'(spo2_level);
    end
    if (pick >= 92) begin
      valid = 1'b0;
      spo2  = 8'($urandom);
      hr    = 8'($urandom);
    end
    send_sample(restart, spo2, hr, valid);
  endtask

  initial begin
    bit [7:0] drop;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cycle_count = 0;
    sent        = 0;
    steady      = 1'b0;
    spo2_level  = 96;
    board       = new();

    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      receive_results();
    join_none

    // Directed part under the reset register values. The first samples see
    // a short history only.
    send_sample(1'b0, 8'd97, 8'd60, 1'b1);
    send_sample(1'b0, 8'd98, 8'd255, 1'b1);
    send_sample(1'b0, 8'd95, 8'd61, 1'b1);   // drop of three starts an event
    send_sample(1'b0, 8'd94, 8'd62, 1'b1);   // still in it, counted once
    send_sample(1'b0, 8'd255, 8'd255, 1'b0); // invalid: stored as zero, no stats
    send_sample(1'b0, 8'd97, 8'd63, 1'b1);   // drop of one does not release
    send_sample(1'b0, 8'd98, 8'd64, 1'b1);   // no drop: event ends
    send_sample(1'b0, 8'd0, 8'd0, 1'b1);     // lowest values
    send_sample(1'b0, 8'd255, 8'd0, 1'b1);
    send_sample(1'b0, 8'd255, 8'd255, 1'b1); // highest values
    send_sample(1'b1, 8'd90, 8'd70, 1'b1);   // restart with a valid sample
    send_sample(1'b1, 8'd0, 8'd0, 1'b0);     // restart with an invalid sample
    send_sample(1'b0, 8'd89, 8'd100, 1'b1);  // under the high limit only
    send_sample(1'b0, 8'd87, 8'd99, 1'b1);   // under both limits
    send_sample(1'b0, 8'd88, 8'd98, 1'b1);   // on the low limit
    send_sample(1'b0, 8'd0, 8'd0, 1'b0);
    drain();

    // Random phases, each under its own register setting. The first ones
    // hit the register extremes, including window values that get clamped
    // and writes to addresses past the register list.
    for (int p = 0; p < PHASES; p++) begin
      steady = (p == 2 || p == 5);
      case (p)
        0: configure(8'd2, 8'd1, 8'd0, 8'd255, 8'd0);
        1: configure(8'd255, 8'd255, 8'd255, 8'd0, 8'd255);
        2: begin
          configure(8'd0, 8'd3, 8'd1, 8'd90, 8'd88);
          write_reg(5'd20, 8'($urandom));
          write_reg(5'd28, 8'($urandom));
        end
        3: configure(8'd1, 8'd2, 8'd2, 8'd95, 8'd85);
        4: configure(8'd128, 8'd4, 8'd2, 8'd92, 8'd80);
        default: begin
          drop = 8'($urandom_range(1, 8));
          configure(8'($urandom_range(0, 40)), drop, 8'($urandom_range(0, drop)),
                    8'($urandom_range(80, 100)), 8'($urandom_range(75, 95)));
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_sample();
      drain();
    end

    // Allow any stray result to show up before judging the run.
    repeat (WIN_DEPTH + 16) @(posedge clk);

    $display("Sent %0d samples over %0d register settings plus reset values.",
             sent, PHASES);
    $display("Checked %0d results; %0d desaturation events were predicted to start.",
             board.checked, board.starts);
    if (board.errors == 0 && board.pending_summaries.size() == 0) begin
      $display("oximetry_desaturation_tracker_core_test: done, clean");
    end else begin
      $display("oximetry_desaturation_tracker_core_test: done, errors");
    end
    $finish;
  end

endmodule
